### src/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CELL_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CELL_W-1:0] ATTR_WHITE = 16'h0F00;
  localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
  localparam logic              FUNC_READ  = 1'b1;

  typedef enum logic [1:0] {
    OP_READ,
    OP_CHAR,
    OP_LF,
    OP_CR
  } op_t;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] char_byte;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_column;
    logic              last_in_buffer;
  } in_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic              scrolled;
    logic              last_out;
  } out_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] char_byte;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_column;
    logic              in_range;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } status_t;

endpackage

`default_nettype wire

### src/tcw_front.sv
`default_nettype none

module tcw_front (
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire tcw_pkg::in_t    item,
  input  wire tcw_pkg::status_t status,
  input  wire logic            q_full,
  output logic                 push,
  output tcw_pkg::cmd_t        cmd
);
  import tcw_pkg::*;

  assign item_ready = !status.clearing && !q_full;
  assign push       = item_valid && item_ready;

  always_comb begin
    cmd.char_byte   = item.char_byte;
    cmd.read_row    = item.read_row;
    cmd.read_column = item.read_column;
    cmd.last        = item.last_in_buffer;
    cmd.in_range    = (item.read_row < ROW_W'(ROWS)) && (item.read_column < COL_W'(COLUMNS));
    if (item.func == FUNC_READ) begin
      cmd.op = OP_READ;
    end else if (item.char_byte == BYTE_LF) begin
      cmd.op = OP_LF;
    end else if (item.char_byte == BYTE_CR) begin
      cmd.op = OP_CR;
    end else begin
      cmd.op = OP_CHAR;
    end
  end

endmodule

`default_nettype wire

### src/tcw_queue.sv
`default_nettype none

module tcw_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tcw_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output tcw_pkg::cmd_t      pop_cmd,
  output logic               empty
);
  import tcw_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/tcw_back.sv
`default_nettype none

module tcw_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire tcw_pkg::cmd_t cmd,
  output logic               pop,
  output tcw_pkg::status_t   status,
  output logic               result_valid,
  input  wire logic          result_ready,
  output tcw_pkg::out_t      result
);
  import tcw_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_BLANK = 4'b1000
  } state_t;

  // Rows are kept in a ring: logical row r lives in physical row (r + top) mod ROWS.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_W:0]   sum;
    logic [ROW_W-1:0] prow;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= (ROW_W + 1)'(ROWS)) begin
      sum = sum - (ROW_W + 1)'(ROWS);
    end
    prow = sum[ROW_W-1:0];
    return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

  logic [CELL_W-1:0] mem [CELLS];

  state_t            state, state_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  top, top_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [ADDR_W-1:0] blank_base, blank_base_next;
  logic [COL_W-1:0]  blank_col, blank_col_next;
  logic              res_valid, res_valid_next;
  out_t              res, res_next;
  logic [CELL_W-1:0] rd_data;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              step_row;

  assign status.clearing = (state == ST_CLEAR);
  assign result_valid    = res_valid;
  assign result          = res;
  assign mem_raddr       = cell_addr(cmd.read_row, top, cmd.read_column);

  always_comb begin
    state_next      = state;
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    top_next        = top;
    clr_addr_next   = clr_addr;
    blank_base_next = blank_base;
    blank_col_next  = blank_col;
    res_valid_next  = res_valid && !result_ready;
    res_next        = res;
    mem_we          = 1'b0;
    mem_waddr       = clr_addr;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    pop             = 1'b0;
    step_row        = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == ADDR_W'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (!q_empty && (!res_valid || result_ready)) begin
          pop                 = 1'b1;
          res_next.cell_value = '0;
          res_next.scrolled   = 1'b0;
          res_next.last_out   = cmd.last;
          res_valid_next      = 1'b1;
          case (cmd.op)
            OP_READ: begin
              if (cmd.in_range) begin
                mem_re         = 1'b1;
                res_valid_next = 1'b0;
                state_next     = ST_READ;
              end
            end
            OP_CR: begin
              cur_col_next = '0;
            end
            OP_LF: begin
              cur_col_next = '0;
              step_row     = 1'b1;
            end
            OP_CHAR: begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr(cur_row, top, cur_col);
              mem_wdata = ATTR_WHITE | {{(CELL_W - BYTE_W){1'b0}}, cmd.char_byte};
              if (cur_col == COL_W'(COLUMNS - 1)) begin
                cur_col_next = '0;
                step_row     = 1'b1;
              end else begin
                cur_col_next = cur_col + COL_W'(1);
              end
            end
            default: begin
              cur_col_next = cur_col;
            end
          endcase
          if (step_row) begin
            if (cur_row == ROW_W'(ROWS - 1)) begin
              // The old top row becomes the new bottom row and is blanked.
              top_next          = (top == ROW_W'(ROWS - 1)) ? '0 : top + ROW_W'(1);
              blank_base_next   = cell_addr('0, top, '0);
              blank_col_next    = '0;
              state_next        = ST_BLANK;
              res_next.scrolled = 1'b1;
            end else begin
              cur_row_next = cur_row + ROW_W'(1);
            end
          end
          res_next.cursor_row    = cur_row_next;
          res_next.cursor_column = cur_col_next;
        end
      end
      ST_READ: begin
        res_next.cell_value = rd_data;
        res_valid_next      = 1'b1;
        state_next          = ST_IDLE;
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = blank_base + ADDR_W'(blank_col);
        if (blank_col == COL_W'(COLUMNS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          blank_col_next = blank_col + COL_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cur_row    <= '0;
      cur_col    <= '0;
      top        <= '0;
      clr_addr   <= '0;
      blank_base <= '0;
      blank_col  <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur_row    <= cur_row_next;
      cur_col    <= cur_col_next;
      top        <= top_next;
      clr_addr   <= clr_addr_next;
      blank_base <= blank_base_next;
      blank_col  <= blank_col_next;
      res_valid  <= res_valid_next;
    end
  end

endmodule

`default_nettype wire

### src/text_console_writer.sv
`default_nettype none

// Channel   Signals                           Direction  Payload
// item      item_valid / item_ready / item    in         tcw_pkg::in_t
// result    result_valid / result_ready / result  out    tcw_pkg::out_t
//
// Characters, carriage returns, line feeds, and reads outside the screen finish in
// the idle state; reads of a screen cell also pass through the read state because
// the screen memory read is registered.
// A scroll adds a pass that blanks the recycled bottom row.
// After reset a pass clears the screen memory and no item is taken.
// A two-entry command queue lets transfers continue while a result waits.
module text_console_writer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire tcw_pkg::in_t  item,
  output logic               result_valid,
  input  wire logic          result_ready,
  output tcw_pkg::out_t      result
);
  import tcw_pkg::*;

  status_t status;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;

  tcw_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .status     (status),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  tcw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .cmd          (pop_cmd),
    .pop          (pop),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

### dv/text_console_writer_tb.sv
`timescale 1ns / 1ps

module text_console_writer_tb;
  import tcw_pkg::*;

  localparam logic        FUNC_WRITE   = ~FUNC_READ;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int          IN_W         = $bits(in_t);

  typedef struct packed {
    in_t  stim;
    logic typed;
    out_t want;
  } step_row_t;

  logic clk;
  logic rst          = 1'b1;
  logic item_valid   = 1'b0;
  logic item_ready;
  in_t  item         = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_t result;

  text_console_writer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  logic [CELL_W-1:0] screen_model [CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  out_t              pending_results [$];
  step_row_t         directed_rows [$];
  int unsigned       mismatches   = 0;
  int unsigned       results_seen = 0;
  int unsigned       scrolls_seen = 0;
  int unsigned       items_sent   = 0;
  int unsigned       writes_sent  = 0;
  int unsigned       reads_sent   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic op_t classify(in_t x);
    if (x.func == FUNC_READ) return OP_READ;
    if (x.char_byte == BYTE_LF) return OP_LF;
    if (x.char_byte == BYTE_CR) return OP_CR;
    return OP_CHAR;
  endfunction

  // Moving below the last row shifts every row up and blanks the bottom one.
  function automatic logic advance_row();
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = '0;
      cur_row = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_t console_step(in_t x);
    out_t y;
    y = '0;
    case (classify(x))
      OP_READ: begin
        if (x.read_row < ROWS && x.read_column < COLUMNS)
          y.cell_value = screen_model[x.read_column + COLUMNS * x.read_row];
      end
      OP_LF: begin
        y.scrolled = advance_row();
        cur_col = 0;
      end
      OP_CR: begin
        cur_col = 0;
      end
      OP_CHAR: begin
        screen_model[cur_col + COLUMNS * cur_row] = ATTR_WHITE | x.char_byte;
        cur_col++;
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          y.scrolled = advance_row();
        end
      end
      default: begin
        y = '0;
      end
    endcase
    y.cursor_row    = cur_row[ROW_W-1:0];
    y.cursor_column = cur_col[COL_W-1:0];
    y.last_out      = x.last_in_buffer;
    return y;
  endfunction

  function automatic in_t text_item(logic [BYTE_W-1:0] b, logic last);
    in_t x;
    x.func           = FUNC_WRITE;
    x.char_byte      = b;
    x.read_row       = ROW_W'($urandom_range(0, 31));
    x.read_column    = COL_W'($urandom_range(0, 127));
    x.last_in_buffer = last;
    return x;
  endfunction

  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic compare_result(out_t got, out_t want);
    if (got.cell_value !== want.cell_value)
      report_mismatch($sformatf("result %0d cell_value %h, expected %h",
                                results_seen, got.cell_value, want.cell_value));
    if (got.cursor_row !== want.cursor_row)
      report_mismatch($sformatf("result %0d cursor_row %0d, expected %0d",
                                results_seen, got.cursor_row, want.cursor_row));
    if (got.cursor_column !== want.cursor_column)
      report_mismatch($sformatf("result %0d cursor_column %0d, expected %0d",
                                results_seen, got.cursor_column, want.cursor_column));
    if (got.scrolled !== want.scrolled)
      report_mismatch($sformatf("result %0d scrolled %b, expected %b",
                                results_seen, got.scrolled, want.scrolled));
    if (got.last_out !== want.last_out)
      report_mismatch($sformatf("result %0d last_out %b, expected %b",
                                results_seen, got.last_out, want.last_out));
  endtask

  task automatic add_row(logic f, logic [BYTE_W-1:0] b, logic [ROW_W-1:0] r,
                         logic [COL_W-1:0] c, logic last, logic typed,
                         logic [CELL_W-1:0] cell_want, logic [ROW_W-1:0] crow,
                         logic [COL_W-1:0] ccol);
    step_row_t row;
    row.stim                = '{func: f, char_byte: b, read_row: r, read_column: c,
                                last_in_buffer: last};
    row.typed               = typed;
    row.want.cell_value     = cell_want;
    row.want.cursor_row     = crow;
    row.want.cursor_column  = ccol;
    row.want.scrolled       = 1'b0;
    row.want.last_out       = last;
    directed_rows.push_back(row);
  endtask

  // The predictor runs at the edge where the transfer is taken, so its cursor
  // is always current for the next item.
  task automatic send_item(in_t x, int unsigned gap);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= x;
    do @(posedge clk); while (!item_ready);
    pending_results.push_back(console_step(x));
    items_sent++;
    if (x.func == FUNC_READ) reads_sent++;
    else writes_sent++;
  endtask

  initial begin
    int unsigned burst_kind;
    int unsigned len;
    int unsigned ending;
    bit          steady;
    in_t         x;

    foreach (screen_model[i]) screen_model[i] = '0;
    cur_row = 0;
    cur_col = 0;

    add_row(FUNC_READ,  8'h00,   5'd0,  7'd0,   1'b0, 1'b1, 16'h0000, 5'd0, 7'd0);
    add_row(FUNC_READ,  8'hFF,   5'd24, 7'd79,  1'b1, 1'b1, 16'h0000, 5'd0, 7'd0);
    add_row(FUNC_READ,  8'h00,   5'd31, 7'd127, 1'b0, 1'b1, 16'h0000, 5'd0, 7'd0);
    add_row(FUNC_READ,  8'h00,   5'd25, 7'd0,   1'b0, 1'b1, 16'h0000, 5'd0, 7'd0);
    add_row(FUNC_READ,  8'h00,   5'd0,  7'd80,  1'b1, 1'b1, 16'h0000, 5'd0, 7'd0);
    add_row(FUNC_WRITE, 8'h41,   5'd0,  7'd0,   1'b0, 1'b1, 16'h0000, 5'd0, 7'd1);
    add_row(FUNC_WRITE, 8'h00,   5'd31, 7'd127, 1'b0, 1'b1, 16'h0000, 5'd0, 7'd2);
    add_row(FUNC_WRITE, 8'hFF,   5'd0,  7'd0,   1'b1, 1'b1, 16'h0000, 5'd0, 7'd3);
    add_row(FUNC_READ,  8'h00,   5'd0,  7'd0,   1'b0, 1'b1, 16'h0F41, 5'd0, 7'd3);
    add_row(FUNC_READ,  8'h00,   5'd0,  7'd1,   1'b0, 1'b1, 16'h0F00, 5'd0, 7'd3);
    add_row(FUNC_READ,  8'h00,   5'd0,  7'd2,   1'b1, 1'b1, 16'h0FFF, 5'd0, 7'd3);
    add_row(FUNC_WRITE, BYTE_CR, 5'd0,  7'd0,   1'b0, 1'b1, 16'h0000, 5'd0, 7'd0);
    add_row(FUNC_WRITE, 8'h0B,   5'd31, 7'd127, 1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_READ,  8'h00,   5'd0,  7'd0,   1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_WRITE, BYTE_LF, 5'd0,  7'd0,   1'b1, 1'b0, '0, '0, '0);
    add_row(FUNC_READ,  BYTE_LF, 5'd1,  7'd0,   1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_WRITE, 8'h0C,   5'd0,  7'd0,   1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_WRITE, 8'h0E,   5'd0,  7'd0,   1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_WRITE, BYTE_LF, 5'd0,  7'd0,   1'b1, 1'b0, '0, '0, '0);
    add_row(FUNC_READ,  8'h00,   5'd1,  7'd1,   1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_READ,  8'h00,   5'd1,  7'd79,  1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_WRITE, 8'h80,   5'd0,  7'd0,   1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_READ,  BYTE_CR, 5'd2,  7'd0,   1'b1, 1'b0, '0, '0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].stim, pick_gap(1'b0));
      if (directed_rows[i].typed) pending_results[$] = directed_rows[i].want;
    end

    // Most traffic is write calls of text lines, some long enough to wrap,
    // mixed with screen reads and a little raw noise.
    while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
      steady     = ((items_sent / 80) % 4) == 3;
      burst_kind = $urandom_range(0, 99);
      if (burst_kind < 60) begin
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 170) : $urandom_range(1, 30);
        ending = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
          x = text_item(BYTE_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(8'h20, 8'h7E)),
                        ending == 3 && i == len - 1);
          send_item(x, pick_gap(steady));
        end
        if (ending == 2) send_item(text_item(BYTE_CR, 1'b0), pick_gap(steady));
        if (ending != 3) send_item(text_item(BYTE_LF, 1'b1), pick_gap(steady));
      end else if (burst_kind < 85) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          x.func           = FUNC_READ;
          x.char_byte      = BYTE_W'($urandom_range(0, 255));
          x.last_in_buffer = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 9) == 0) begin
            x.read_row    = ROW_W'($urandom_range(0, 31));
            x.read_column = COL_W'($urandom_range(0, 127));
          end else begin
            x.read_row    = ROW_W'(($urandom_range(0, 2) == 0) ? cur_row
                                                               : $urandom_range(0, ROWS - 1));
            x.read_column = COL_W'($urandom_range(0, COLUMNS - 1));
          end
          send_item(x, pick_gap(steady));
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          x = in_t'(IN_W'($urandom()));
          send_item(x, pick_gap(steady));
        end
      end
    end

    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Summary: %0d items sent (%0d writes, %0d reads), %0d results checked.",
             items_sent, writes_sent, reads_sent, results_seen);
    $display("Summary: %0d scrolls observed, %0d mismatches.", scrolls_seen, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: checks each transfer in order and stalls ready at random,
  // with quiet stretches where ready stays high.
  initial begin
    int unsigned stall;
    int unsigned cycles;
    out_t        want;
    stall  = 0;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (result_valid && result_ready) begin
        results_seen++;
        if (result.scrolled) scrolls_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d with nothing outstanding",
                                    results_seen));
        end else begin
          want = pending_results.pop_front();
          compare_result(result, want);
        end
      end
      if (stall != 0) begin
        result_ready <= 1'b0;
        stall--;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap(((cycles / 600) % 4) == 1);
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) idle = 0;
      else idle++;
    end
    $display("Timeout: no transfer for %0d cycles, %0d results outstanding.",
             IDLE_LIMIT, pending_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
